[hdl/assert_macros.svh]
// Assertion macros for the RTL; included by small_float_add_sub.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[hdl/sfas_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfas_pkg
// Shared constants for the small float adder/subtractor.
// ----------------------------------------------------------------------------
package sfas_pkg;
	localparam int TOTAL_BITS = 16;
	localparam int EXP_BITS   = 5;
	localparam int MANT_BITS  = 10;

	// Request codes carried on req_type.
	localparam logic OP_ADD = 1'b0;
	localparam logic OP_SUB = 1'b1;
endpackage

[hdl/small_float_add_sub.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_float_add_sub
// Truncating adder/subtractor for small sign/exponent/mantissa words.
// ----------------------------------------------------------------------------
// A word is accepted on a rising edge with start high and busy low; busy is
// always low, so a word may be offered every cycle. The operands are
// registered at the accepting edge, pass through one combinational
// align/add/normalise stage into the result register at the next edge, and
// the result then sits on sum_word with done high for one cycle. Throughput
// is one word per cycle, set by the single registered pass. The receiver
// cannot stall the block; each result is presented once. Reset clears the
// valid flags, so no result is reported until a word has been accepted. No
// rounding, infinity, NaN or subnormals.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module small_float_add_sub #(
	parameter int TOTAL_BITS = sfas_pkg::TOTAL_BITS,
	parameter int EXP_BITS   = sfas_pkg::EXP_BITS,
	parameter int MANT_BITS  = sfas_pkg::MANT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  req_type,
	input  logic [TOTAL_BITS-1:0] operand_x,
	input  logic [TOTAL_BITS-1:0] operand_y,
	output logic                  done,
	output logic [TOTAL_BITS-1:0] sum_word
);
	logic                  vld_s1, vld_s2;
	logic                  req_s1;
	logic [TOTAL_BITS-1:0] x_s1, y_s1, res_s2, res_c;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req_type;
			x_s1   <= operand_x;
			y_s1   <= operand_y;
		end
		if (vld_s1) res_s2 <= res_c;
	end

	sfas_core #(
		.TOTAL_BITS(TOTAL_BITS), .EXP_BITS(EXP_BITS), .MANT_BITS(MANT_BITS)
	) u_core (
		.req_type(req_s1), .operand_x(x_s1), .operand_y(y_s1), .sum_word(res_c)
	);

	assign done     = vld_s2;
	assign sum_word = res_s2;

	`ASSERT_NEXT(a_done_follows, clk, arst_n, vld_s1, done)
	`ASSERT_NEXT(a_no_spurious, clk, arst_n, !vld_s1, !done)
	`ASSERT_IMPL(a_never_busy, clk, arst_n, !busy)
endmodule

[hdl/sfas_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfas_core
// Combinational align, add, normalise and pack of one operand pair.
// ----------------------------------------------------------------------------
module sfas_core #(
	parameter int TOTAL_BITS = sfas_pkg::TOTAL_BITS,
	parameter int EXP_BITS   = sfas_pkg::EXP_BITS,
	parameter int MANT_BITS  = sfas_pkg::MANT_BITS
) (
	input  logic                  req_type,
	input  logic [TOTAL_BITS-1:0] operand_x,
	input  logic [TOTAL_BITS-1:0] operand_y,
	output logic [TOTAL_BITS-1:0] sum_word
);
	localparam int SW = MANT_BITS + 3;   // signed significand sum width
	localparam int MW = MANT_BITS + 2;   // magnitude width
	localparam int PW = $clog2(MW + 1) + 1;
	localparam int ERW = EXP_BITS + PW + 2;
	localparam logic [TOTAL_BITS-1:0] SIGN = {1'b1, {(TOTAL_BITS-1){1'b0}}};

	logic [TOTAL_BITS-1:0] y;
	logic [EXP_BITS-1:0] ex, ey, d;
	logic signed [SW-1:0] sx, sy, ax, ay, sum;
	logic [MW-1:0] mag, nmag;
	logic [PW-1:0] pos;
	logic found;
	logic signed [ERW-1:0] er;
	logic [TOTAL_BITS-1:0] packed_w;

	always_comb begin
		y = operand_y;
		if (req_type == sfas_pkg::OP_SUB && operand_y != '0) y = operand_y ^ SIGN;
		ex = operand_x[MANT_BITS +: EXP_BITS];
		ey = y[MANT_BITS +: EXP_BITS];
		sx = SW'({1'b1, operand_x[MANT_BITS-1:0]});
		sy = SW'({1'b1, y[MANT_BITS-1:0]});
		if (operand_x[TOTAL_BITS-1]) sx = -sx;
		if (y[TOTAL_BITS-1]) sy = -sy;
		ax = sx;
		ay = sy;
		if (ex > ey) begin
			d = ex - ey;
			ay = sy >>> d;
			er = ERW'(ex);
		end else begin
			d = ey - ex;
			ax = sx >>> d;
			er = ERW'(ey);
		end
		sum = ax + ay;
		mag = sum[SW-1] ? MW'(-sum) : MW'(sum);
		pos = '0;
		found = 1'b0;
		for (int i = 0; i < MW; i++) begin
			if (mag[i]) begin
				pos = PW'(i);
				found = 1'b1;
			end
		end
		if (!found) begin
			nmag = '0;
			er = er - ERW'(MANT_BITS + 1);
		end else if (pos > PW'(MANT_BITS)) begin
			nmag = mag >> (pos - PW'(MANT_BITS));
			er = er + ERW'(pos) - ERW'(MANT_BITS);
		end else begin
			nmag = mag << (PW'(MANT_BITS) - pos);
			er = er - ERW'(PW'(MANT_BITS) - pos);
		end
		packed_w = ({sum[SW-1], {(TOTAL_BITS-1){1'b0}}})
			| (TOTAL_BITS'(er) << MANT_BITS)
			| TOTAL_BITS'(nmag[MANT_BITS-1:0]);
		if (operand_x == '0) sum_word = y;
		else if (y == '0) sum_word = operand_x;
		else if (operand_x == (y ^ SIGN)) sum_word = '0;
		else sum_word = packed_w;
	end
endmodule

[tb/small_float_add_sub_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_float_add_sub_tb
// Self-checking bench for the truncating small float adder/subtractor.
// Words go in as bursts with random gaps. Each result is compared with a
// behavioural model of the align, add, normalise and pack path.
// ----------------------------------------------------------------------------
module small_float_add_sub_tb;
	localparam int   TOTAL_BITS = sfas_pkg::TOTAL_BITS;
	localparam int   EXP_BITS   = sfas_pkg::EXP_BITS;
	localparam int   MANT_BITS  = sfas_pkg::MANT_BITS;
	localparam logic OP_ADD = sfas_pkg::OP_ADD;
	localparam logic OP_SUB = sfas_pkg::OP_SUB;
	localparam int   WATCHDOG_LIMIT = 2000;
	localparam logic [TOTAL_BITS-1:0] SIGN_ONLY = {1'b1, {(TOTAL_BITS-1){1'b0}}};

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  req_type;
	logic [TOTAL_BITS-1:0] operand_x;
	logic [TOTAL_BITS-1:0] operand_y;
	logic                  done;
	logic [TOTAL_BITS-1:0] sum_word;

	logic [TOTAL_BITS-1:0] sum_queue[$];
	int                    error_count = 0;
	int                    words_sent;
	int                    sums_checked = 0;
	int                    idle_cycles = 0;

	small_float_add_sub i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .operand_x(operand_x), .operand_y(operand_y),
		.done(done), .sum_word(sum_word)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic [TOTAL_BITS-1:0] flip_sign(logic [TOTAL_BITS-1:0] w);
		if (w == '0)
			return '0;
		return w ^ SIGN_ONLY;
	endfunction

	function automatic logic signed [63:0] signif(logic [TOTAL_BITS-1:0] w);
		logic signed [63:0] m;
		m = 64'({1'b1, w[MANT_BITS-1:0]});
		return w[TOTAL_BITS-1] ? -m : m;
	endfunction

	function automatic logic [TOTAL_BITS-1:0] float_sum(logic op,
			logic [TOTAL_BITS-1:0] x, logic [TOTAL_BITS-1:0] y);
		logic signed [63:0] ex, ey, sx, sy, er, total;
		logic [63:0] mag, packed_word;
		logic sgn;
		int lead, d;
		if (op == OP_SUB)
			y = flip_sign(y);
		if (x == '0)
			return y;
		if (y == '0)
			return x;
		if (x == flip_sign(y) || y == flip_sign(x))
			return '0;
		ex = 64'(x[MANT_BITS +: EXP_BITS]);
		ey = 64'(y[MANT_BITS +: EXP_BITS]);
		sx = signif(x);
		sy = signif(y);
		if (ex > ey) begin
			er = ex;
			d = (ex - ey > 62) ? 62 : int'(ex - ey);
			sy = sy >>> d;
		end else begin
			er = ey;
			d = (ey - ex > 62) ? 62 : int'(ey - ex);
			sx = sx >>> d;
		end
		total = sx + sy;
		sgn = total < 0;
		mag = sgn ? -total : total;
		lead = -1;
		for (int i = 63; i >= 0; i--)
			if (lead < 0 && mag[i])
				lead = i;
		if (lead > MANT_BITS) begin
			mag = mag >> (lead - MANT_BITS);
			er = er + (lead - MANT_BITS);
		end else if (lead < MANT_BITS) begin
			mag = mag << (MANT_BITS - lead);
			er = er - (MANT_BITS - lead);
		end
		mag = mag & ((64'd1 << MANT_BITS) - 1);
		packed_word = (64'(sgn) << (TOTAL_BITS - 1)) | (64'(er) << MANT_BITS) | mag;
		return packed_word[TOTAL_BITS-1:0];
	endfunction

	// Sends one word; the call returns at a falling edge after the accepting edge.
	task automatic send_word(logic op, logic [TOTAL_BITS-1:0] x, logic [TOTAL_BITS-1:0] y,
			bit keep_start);
		start <= 1'b1;
		req_type <= op;
		operand_x <= x;
		operand_y <= y;
		do @(posedge clk); while (busy);
		sum_queue.push_back(float_sum(op, x, y));
		words_sent++;
		@(negedge clk);
		if (!keep_start) begin
			start <= 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic idle_gap(int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	function automatic logic [TOTAL_BITS-1:0] rand_float(int style);
		logic [TOTAL_BITS-1:0] w;
		w = TOTAL_BITS'($urandom_range(0, 65535));
		case (style)
			0: w[MANT_BITS +: EXP_BITS] = EXP_BITS'($urandom_range(12, 18));
			1: w = '0;
			2: w = SIGN_ONLY;
			default: ;
		endcase
		return w;
	endfunction

	task automatic test_directed();
		logic [TOTAL_BITS-1:0] corners[8] = '{16'h0000, 16'h8000, 16'h7fff, 16'hffff,
			16'h3c00, 16'hbc00, 16'h0001, 16'h7c00};
		for (int i = 0; i < 8; i++)
			send_word(i[0] ? OP_SUB : OP_ADD, corners[i], corners[(i * 3 + 1) % 8], 1'b0);
		send_word(OP_ADD, 16'h3c00, 16'hbc00, 1'b1);  // exact negation
		send_word(OP_SUB, 16'h3c00, 16'h3c00, 1'b1);
		send_word(OP_SUB, 16'h1234, 16'h0000, 1'b1);
		send_word(OP_SUB, 16'h0000, 16'h1234, 1'b0);
		send_word(OP_SUB, 16'h4321, 16'h8000, 1'b0);  // negative zero becomes zero
		send_word(OP_ADD, 16'h7c00, 16'h0400, 1'b1);  // wide gap, positive shift
		send_word(OP_ADD, 16'h7c00, 16'h8400, 1'b1);  // wide gap, negative shift
		send_word(OP_ADD, 16'h7bff, 16'h7bff, 1'b1);  // carry raises the exponent to its largest value
		send_word(OP_SUB, 16'h0400, 16'h0401, 1'b1);  // exponent underflow
		send_word(OP_ADD, 16'h3c00, 16'h3c00, 1'b0);
		send_word(OP_SUB, 16'h3e00, 16'h3c00, 1'b0);
	endtask

	task automatic test_random(int n);
		int left, burst;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			if (burst > left)
				burst = left;
			for (int i = 0; i < burst; i++) begin
				int style;
				logic [TOTAL_BITS-1:0] x, y;
				style = $urandom_range(0, 19);
				x = rand_float(style < 10 ? 0 : (style == 10 ? 1 : (style == 11 ? 2 : 3)));
				style = $urandom_range(0, 19);
				y = rand_float(style < 10 ? 0 : (style == 10 ? 1 : (style == 11 ? 2 : 3)));
				if ($urandom_range(0, 15) == 0)
					y = flip_sign(x);
				else if ($urandom_range(0, 15) == 0)
					y = x;
				send_word(1'($urandom_range(0, 1)), x, y, i != burst - 1);
			end
			left -= burst;
			if ($urandom_range(0, 3) != 0)
				idle_gap($urandom_range(1, 6));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (sum_queue.size() == 0) begin
				$error("sum_word: no result expected, actual %h", sum_word);
				error_count++;
			end else begin
				logic [TOTAL_BITS-1:0] want;
				want = sum_queue.pop_front();
				if (sum_word !== want) begin
					$error("sum_word: expected %h, actual %h", want, sum_word);
					error_count++;
				end
				sums_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d quiet cycles", idle_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int settle;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = OP_ADD;
		operand_x = '0;
		operand_y = '0;
		words_sent = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(1450);
		start <= 1'b0;
		settle = 0;
		while (sum_queue.size() != 0 && settle < 100) begin
			@(negedge clk);
			settle++;
		end
		repeat (5) @(negedge clk);
		if (sum_queue.size() != 0)
			$error("sum_word: %0d expected results never arrived", sum_queue.size());
		$display("Sent %0d words, checked %0d sums across corner, special and random cases.",
			words_sent, sums_checked);
		if (error_count == 0 && sum_queue.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

[files.f]
+incdir+hdl
hdl/sfas_pkg.sv
hdl/sfas_core.sv
hdl/small_float_add_sub.sv
tb/small_float_add_sub_tb.sv
